FILE: sv/assert_macros.svh
// Assertion macros shared by the bit packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/mbp_pkg.sv
// Package with types and constants for the MSB-first bit packer.
package mbp_pkg;

    localparam int MAX_FIELD  = 64;
    localparam int BYTE_BITS  = 8;
    localparam int LEN_W      = 7;
    localparam int STREAM_W   = MAX_FIELD + BYTE_BITS;
    localparam int CNT_W      = 4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cmd_t;

    typedef struct packed {
        logic zero_bytes;
        logic last_byte;
    } status_t;

endpackage

FILE: sv/mbp_ctrl.sv
// Controller state machine of the MSB-first bit packer.
module mbp_ctrl
    import mbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    field_valid,
    output logic    field_ready,
    output logic    byte_valid,
    input  logic    byte_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        field_ready = 1'b0;
        byte_valid  = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                field_ready = 1'b1;
                if (field_valid)
                begin
                    cmd.load = 1'b1;
                    if (!status.zero_bytes)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                byte_valid = 1'b1;
                if (byte_ready)
                begin
                    cmd.shift = 1'b1;
                    if (status.last_byte)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mbp_datapath.sv
// Datapath of the MSB-first bit packer: pending bits, bit stream and byte counter.
module mbp_datapath
    import mbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [MAX_FIELD-1:0] field_value,
    input  logic [LEN_W-1:0]     field_length,
    input  logic                 flush,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic [BYTE_BITS-1:0] out_byte,
    output logic                 last
);

    logic [BYTE_BITS-1:0] pending_bits_reg;
    logic [2:0]           pending_count_reg;
    logic [STREAM_W-1:0]  stream_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [2:0]           rem_reg;
    logic                 flushed_reg;

    logic [LEN_W-1:0]     len_sat;
    logic [LEN_W-1:0]     left_shift;
    logic [MAX_FIELD-1:0] field_left;
    logic [STREAM_W-1:0]  stream_next;
    logic [LEN_W-1:0]     total;
    logic [2:0]           rem;
    logic                 flush_hit;
    logic [CNT_W-1:0]     nbytes;

    always_comb
    begin
        len_sat     = (field_length > LEN_W'(MAX_FIELD)) ? LEN_W'(MAX_FIELD) : field_length;
        left_shift  = LEN_W'(MAX_FIELD) - len_sat;
        // Left-aligning the field drops every bit above its length.
        field_left  = field_value << left_shift;
        stream_next = {pending_bits_reg, {MAX_FIELD{1'b0}}}
                    | ({field_left, {BYTE_BITS{1'b0}}} >> pending_count_reg);
        total       = LEN_W'(pending_count_reg) + len_sat;
        rem         = total[2:0];
        flush_hit   = flush && (rem != 3'd0);
        nbytes      = CNT_W'(total[LEN_W-1:3]) + CNT_W'(flush_hit);
    end

    assign status.zero_bytes = (nbytes == '0);
    assign status.last_byte  = (count_reg == CNT_W'(1));
    assign out_byte          = stream_reg[STREAM_W-1 -: BYTE_BITS];
    assign last              = (count_reg == CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            count_reg         <= '0;
            rem_reg           <= '0;
            flushed_reg       <= 1'b0;
        end
        else if (cmd.load)
        begin
            count_reg   <= nbytes;
            rem_reg     <= rem;
            flushed_reg <= flush_hit;
            if (nbytes == '0)
            begin
                pending_bits_reg  <= stream_next[STREAM_W-1 -: BYTE_BITS];
                pending_count_reg <= rem;
            end
        end
        else if (cmd.shift)
        begin
            count_reg <= count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                pending_bits_reg  <= flushed_reg ? '0
                                   : stream_reg[STREAM_W-BYTE_BITS-1 -: BYTE_BITS];
                pending_count_reg <= flushed_reg ? 3'd0 : rem_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            stream_reg <= stream_next;
        end
        else if (cmd.shift)
        begin
            stream_reg <= stream_reg << BYTE_BITS;
        end
    end

endmodule

FILE: sv/msb_first_bit_packer.sv
// Top level of the MSB-first bit packer: controller and datapath.
//
// Input channel (field_valid / field_ready) carries one transaction per field:
// field_value holds up to 64 bits right-aligned, field_length the count of bits
// to append (values above 64 count as 64), and flush requests that a partial
// byte be emitted, left-aligned and zero padded, after the field is appended.
// Output channel (byte_valid / byte_ready) carries one transaction per
// completed byte; last marks the final byte caused by an input transaction.
// An input that completes no byte produces no output transaction.
// Latency: the first byte is offered the cycle after the input is accepted.
// Throughput: one byte per cycle while the receiver takes them; an input
// yields N = 0 to 9 bytes, and an input that yields no byte leaves the
// controller idle. The byte shift register drains one byte a cycle and
// the next input is accepted once the last byte is taken.
// When the receiver stalls, the current byte and last stay unchanged and
// no further input is accepted.
// Reset (rst_n low, asynchronous) clears the pending bits and returns the
// controller to idle, ready for an input.
`include "assert_macros.svh"

module msb_first_bit_packer
    import mbp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 field_valid,
    output logic                 field_ready,
    input  logic [MAX_FIELD-1:0] field_value,
    input  logic [LEN_W-1:0]     field_length,
    input  logic                 flush,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output logic [BYTE_BITS-1:0] out_byte,
    output logic                 last
);

    cmd_t    cmd;
    status_t status;

    // The controller sequences loading a field and draining its bytes.
    mbp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .field_valid (field_valid),
        .field_ready (field_ready),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // The datapath merges the field with the pending bits and shifts bytes out.
    mbp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .field_value  (field_value),
        .field_length (field_length),
        .flush        (flush),
        .cmd          (cmd),
        .status       (status),
        .out_byte     (out_byte),
        .last         (last)
    );

    // Input and output are never offered in the same cycle.
    `ASSERT_CLK(a_ready_excl, !(field_ready && byte_valid), "ready while a byte is pending")
    // A byte taken without last must be followed by another byte.
    `ASSERT_NEXT(a_more_bytes, byte_valid && byte_ready && !last, byte_valid, "byte run ended early")
    // An empty field without flush produces no byte.
    `ASSERT_NEXT(a_empty_field, field_valid && field_ready && field_length == '0 && !flush, !byte_valid, "empty field made a byte")

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the MSB-first bit packer.
`timescale 1ns / 1ps

module testbench;
    import mbp_pkg::*;

    // Cycles without any transaction on either channel before the run is
    // declared hung. The longest legal quiet stretch is the long receiver
    // hold-off below, so this leaves a wide margin.
    localparam int STALL_LIMIT  = 3000;
    // Cycles allowed after the last expected byte so that stray output shows up.
    localparam int DRAIN_CYCLES = 12;
    // Length of the long receiver hold-off used to fill the block up.
    localparam int LONG_HOLD    = 300;
    localparam int MAX_REPORTS  = 10;

    // One predicted output transaction.
    typedef struct packed {
        logic [BYTE_BITS-1:0] data;
        logic                 last;
    } packed_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 field_valid;
    logic                 field_ready;
    logic [MAX_FIELD-1:0] field_value;
    logic [LEN_W-1:0]     field_length;
    logic                 flush;
    logic                 byte_valid;
    logic                 byte_ready;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 last;

    // Bytes the packer should still produce, oldest first.
    packed_byte_t         packed_bytes[$];

    // Our own copy of the partial byte: bits collected so far, left-aligned.
    logic [BYTE_BITS-1:0] acc_bits;
    int                   acc_count;

    int                   error_count;
    int                   quiet_cycles;
    // When set, both sides insert random idle bursts.
    bit                   idling;
    // Nonzero asks the receiver process to hold byte_ready low this many cycles.
    int                   hold_request;

    msb_first_bit_packer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .field_valid  (field_valid),
        .field_ready  (field_ready),
        .field_value  (field_value),
        .field_length (field_length),
        .flush        (flush),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .out_byte     (out_byte),
        .last         (last)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Appends one field to the partial byte, MSB first, and queues every byte
    // that it completes. Lengths above 64 count as 64, bits of the value above
    // the length never reach the stream, and a flush pushes out any partial
    // byte padded with zeros. The final byte of the transaction carries last.
    function automatic void append_field(input logic [MAX_FIELD-1:0] value,
                                         input logic [LEN_W-1:0] length,
                                         input logic flush_bit);
        logic [BYTE_BITS-1:0] done[0:9];
        packed_byte_t         entry;
        int                   nbits;
        int                   count;
        int                   k;
        nbits = (int'(length) > MAX_FIELD) ? MAX_FIELD : int'(length);
        count = 0;
        for (k = nbits - 1; k >= 0; k--)
        begin
            acc_bits[BYTE_BITS - 1 - acc_count] = value[k];
            acc_count++;
            if (acc_count == BYTE_BITS)
            begin
                done[count] = acc_bits;
                count++;
                acc_bits = '0;
                acc_count = 0;
            end
        end
        // A flush with nothing pending emits nothing.
        if (flush_bit && acc_count != 0)
        begin
            done[count] = acc_bits;
            count++;
            acc_bits = '0;
            acc_count = 0;
        end
        for (k = 0; k < count; k++)
        begin
            entry.data = done[k];
            entry.last = (k == count - 1);
            packed_bytes.push_back(entry);
        end
    endfunction

    // Output checker and predictor update. Inputs only change at the falling
    // edge, so everything read here is stable at the rising edge. The byte
    // check comes first; bytes of a transaction accepted at this same edge can
    // only appear on later cycles, so the order does not matter for the queue.
    always @(posedge clk)
    begin
        packed_byte_t want;
        if (rst_n)
        begin
            if (byte_valid && byte_ready)
            begin
                if (packed_bytes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected byte: got %h last %b", out_byte, last);
                end
                else
                begin
                    want = packed_bytes.pop_front();
                    if (out_byte !== want.data || last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("byte mismatch: expected %h last %b, got %h last %b",
                                     want.data, want.last, out_byte, last);
                    end
                end
            end
            if (field_valid && field_ready)
                append_field(field_value, field_length, flush);
        end
    end

    // Watchdog: ends the run if no transaction happens on either channel
    // for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((field_valid && field_ready) || (byte_valid && byte_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    // Receiver. It either serves a long hold-off that a test asked for,
    // stalls in a random burst while idling is set, or takes bytes.
    initial
    begin
        int burst;
        byte_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                burst = hold_request;
                hold_request = 0;
                byte_ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(1, 8);
                byte_ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                byte_ready = 1'b1;
            end
        end
    end

    // Offers one field and returns at the edge where it is accepted. Valid
    // stays high afterwards, so back-to-back calls give a continuous stream;
    // with idling on, valid may first drop for a random burst.
    task automatic send_field(input logic [MAX_FIELD-1:0] value,
                              input logic [LEN_W-1:0] length,
                              input logic flush_bit);
        int gap;
        if (idling && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            @(negedge clk);
            field_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        field_valid  = 1'b1;
        field_value  = value;
        field_length = length;
        flush        = flush_bit;
        @(posedge clk);
        while (!field_ready)
            @(posedge clk);
    endtask

    // Random field: mostly short lengths, a fair share near and at the full
    // 64 bits, some zero lengths and some lengths that saturate.
    task automatic send_random_field();
        logic [MAX_FIELD-1:0] value;
        logic [LEN_W-1:0]     length;
        int                   pick;
        value = {$urandom, $urandom};
        pick = $urandom_range(0, 19);
        if (pick < 2)
            length = '0;
        else if (pick < 4)
            length = LEN_W'($urandom_range(MAX_FIELD + 1, 127));
        else if (pick < 7)
            length = LEN_W'($urandom_range(MAX_FIELD - 8, MAX_FIELD));
        else
            length = LEN_W'($urandom_range(1, 24));
        send_field(value, length, $urandom_range(0, 4) == 0);
    endtask

    // Drops valid and waits until every predicted byte has been taken.
    task automatic wait_for_drain();
        @(negedge clk);
        field_valid = 1'b0;
        while (packed_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Field extremes, saturated lengths, masked high bits, flushes with and
    // without pending bits, and the nine-byte worst case.
    task automatic test_directed();
        idling = 1'b0;
        send_field('0, 0, 1'b0);                          // zero length, nothing happens
        send_field('0, 0, 1'b1);                          // flush with nothing pending
        send_field({MAX_FIELD{1'b1}}, 64, 1'b0);          // eight bytes of ones
        send_field('0, 64, 1'b0);                         // eight bytes of zeros
        send_field(64'h1, 1, 1'b0);                       // one bit pending
        send_field(64'hFFFF_FFFF_FFFF_FFE5, 5, 1'b0);     // high bits must be masked
        send_field('0, 0, 1'b1);                          // flush a six-bit partial byte
        send_field(64'hA5, 8, 1'b0);
        send_field(64'h5, 3, 1'b0);
        send_field(64'h0123_4567_89AB_CDEF, 64, 1'b1);    // three pending plus 64 plus flush
        send_field(64'hDEAD_BEEF_CAFE_F00D, 127, 1'b0);   // saturates to 64
        send_field(64'h8765_4321_0FED_CBA9, 65, 1'b1);
        send_field(64'h7F, 7, 1'b1);
        send_field(64'h8000_0000_0000_0000, 64, 1'b1);
        send_field(64'h1, 1, 1'b1);
        send_field(64'h5555_5555_5555_5555, 100, 1'b0);
        send_field(64'h2, 2, 1'b0);
        send_field(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);     // zero length with bits pending
        send_field(64'h3F, 6, 1'b0);                      // completes a byte exactly
        send_field('0, 0, 1'b1);                          // flush, nothing pending again
        send_field({MAX_FIELD{1'b1}}, 63, 1'b1);
        send_field(64'hAAAA_AAAA_AAAA_AAAA, 64, 1'b0);
    endtask

    // Random fields with random idling on both channels.
    task automatic test_random_traffic(input int count);
        idling = 1'b1;
        repeat (count) send_random_field();
    endtask

    // The receiver stops for a long stretch while the sender keeps offering,
    // so the block fills up and has to hold off its input.
    task automatic test_backpressure();
        idling = 1'b0;
        hold_request = LONG_HOLD;
        repeat (40) send_random_field();
    endtask

    // Short bursts of traffic, each followed by a pause until the block has
    // delivered everything; each burst ends on a field that yields no byte.
    task automatic test_drain_pauses();
        idling = 1'b1;
        repeat (5)
        begin
            repeat (8) send_random_field();
            send_field({$urandom, $urandom}, 0, 1'b0);
            wait_for_drain();
        end
    endtask

    // Closing stretch at full rate with no idling on either side.
    task automatic test_full_rate(input int count);
        idling = 1'b0;
        repeat (count) send_random_field();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        field_valid  = 1'b0;
        field_value  = '0;
        field_length = '0;
        flush        = 1'b0;
        acc_bits     = '0;
        acc_count    = 0;
        error_count  = 0;
        quiet_cycles = 0;
        idling       = 1'b0;
        hold_request = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(150);
        test_backpressure();
        test_drain_pauses();
        test_full_rate(150);

        wait_for_drain();
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

FILE: msb_first_bit_packer.f
+incdir+sv
sv/mbp_pkg.sv
sv/mbp_ctrl.sv
sv/mbp_datapath.sv
sv/msb_first_bit_packer.sv
bench/testbench.sv
